// ===== rtl/rchd_pkg.sv =====
`timescale 1ns / 1ps

package rchd_pkg;

  // Field widths of one input and one result item.
  localparam int ByteW    = 8;
  localparam int ValueW   = 64;
  localparam int LenW     = 4;
  localparam int ColW     = 16;
  localparam int ClassW   = 4;
  localparam int SizeW    = 63;
  localparam int OffW     = 32;
  localparam int InDataW  = 8;
  localparam int OutDataW = 184;

  // A varint has at most this many bytes; the last one carries all eight bits.
  localparam logic [LenW-1:0] MaxVarintBytes = 4'd9;
  localparam logic [LenW-1:0] FullByteIdx    = 4'd8;

  // Serial types below this value have fixed classes and sizes.
  localparam logic [ValueW-1:0] FirstVarSerial = 64'd12;
  localparam logic [SizeW-1:0]  VarSizeBias    = 63'd6;

  localparam logic [OffW-1:0] OffMax = 32'hFFFF_FFFF;
  localparam logic [ColW-1:0] ColMax = 16'hFFFF;

  // Kind of a decoded varint; also the decoding phase of a cell.
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ROWID    = 2'd1,
    KIND_HDR_SIZE = 2'd2,
    KIND_SERIAL   = 2'd3
  } kind_t;

  // Type classes.
  localparam logic [ClassW-1:0] CLS_NULL     = 4'd0;
  localparam logic [ClassW-1:0] CLS_INT8     = 4'd1;
  localparam logic [ClassW-1:0] CLS_INT16    = 4'd2;
  localparam logic [ClassW-1:0] CLS_INT24    = 4'd3;
  localparam logic [ClassW-1:0] CLS_INT32    = 4'd4;
  localparam logic [ClassW-1:0] CLS_INT48    = 4'd5;
  localparam logic [ClassW-1:0] CLS_INT64    = 4'd6;
  localparam logic [ClassW-1:0] CLS_FLOAT64  = 4'd7;
  localparam logic [ClassW-1:0] CLS_ZERO     = 4'd8;
  localparam logic [ClassW-1:0] CLS_ONE      = 4'd9;
  localparam logic [ClassW-1:0] CLS_RESERVED = 4'd10;
  localparam logic [ClassW-1:0] CLS_BLOB     = 4'd11;
  localparam logic [ClassW-1:0] CLS_TEXT     = 4'd12;

  // One completed varint passed from the front to the back.
  typedef struct packed {
    kind_t             kind;
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   len;
    logic              last;
  } varint_t;

  // Class of a fixed serial type (codes 0 to 11).
  function automatic logic [ClassW-1:0] small_class(input logic [3:0] code);
    logic [ClassW-1:0] cls;
    case (code)
      4'd0:    cls = CLS_NULL;
      4'd1:    cls = CLS_INT8;
      4'd2:    cls = CLS_INT16;
      4'd3:    cls = CLS_INT24;
      4'd4:    cls = CLS_INT32;
      4'd5:    cls = CLS_INT48;
      4'd6:    cls = CLS_INT64;
      4'd7:    cls = CLS_FLOAT64;
      4'd8:    cls = CLS_ZERO;
      4'd9:    cls = CLS_ONE;
      default: cls = CLS_RESERVED;
    endcase
    return cls;
  endfunction

  // Content size of a fixed serial type (codes 0 to 11).
  function automatic logic [3:0] small_size(input logic [3:0] code);
    logic [3:0] sz;
    case (code)
      4'd1:    sz = 4'd1;
      4'd2:    sz = 4'd2;
      4'd3:    sz = 4'd3;
      4'd4:    sz = 4'd4;
      4'd5:    sz = 4'd6;
      4'd6:    sz = 4'd8;
      4'd7:    sz = 4'd8;
      default: sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage

// ===== rtl/record_cell_header_decoder_unit.sv =====
`timescale 1ns / 1ps
// Record cell header decoder.
// Input channel (in_*): one cell byte per item; in_tuser marks the first
// byte of a new cell. Output channel (out_*): one item per completed varint:
// payload size, row id, header size, then one item per column serial type
// with its type class, content size, running content offset and column
// number. out_tlast is set on the item that uses up the record header.
// Bytes that do not finish a varint, and bytes past the header, give no item.
// A varint's final byte, once accepted, writes the varint into the queue; from
// there it is loaded into the output register, which drives out_tvalid.
// Throughput: one byte per cycle while the queue is not full; the front assembles
// a varint byte each cycle and the back classifies one varint each cycle.
// A two-entry queue sits between front and back; when the receiver stalls
// the queue fills and in_tready drops once both entries are held, and it
// rises again as soon as one entry drains.
// Reset (synchronous, rst_n low) empties the queue and output register and
// leaves the decoder expecting a payload size varint.
module record_cell_header_decoder_unit import rchd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [7:0] cell_byte
  input  logic                in_tuser,   // [0] cell_start
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [63:0] value, [67:64] varint_length,
                                          // [83:68] column_index, [87:84] type_class,
                                          // [150:88] content_size,
                                          // [182:151] content_offset, [183] zero
  output logic [1:0]          out_tuser,  // [1:0] kind
  output logic                out_tlast   // last
);

  logic    push, q_full, q_not_empty, pop;
  varint_t push_data, head;
  kind_t   out_kind;

  assign out_tuser = out_kind;

  rchd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rchd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .head      (head)
  );

  rchd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_kind    (out_kind),
    .out_last    (out_tlast)
  );

endmodule

// ===== rtl/rchd_front.sv =====
`timescale 1ns / 1ps

module rchd_front import rchd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_start,
  output logic             push,
  output varint_t          push_data,
  input  logic             q_full
);

  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [LenW-1:0]   nbytes_r, nbytes_nxt;
  kind_t             phase_r, phase_nxt;
  logic [OffW-1:0]   hdr_size_r, hdr_size_nxt;
  logic [OffW-1:0]   hdr_used_r, hdr_used_nxt;

  logic [ValueW-1:0] acc_e, acc_new;
  logic [LenW-1:0]   nbytes_e, len;
  kind_t             phase_e;
  logic [OffW-1:0]   hsize_e, hused_e, hsize_v;
  logic [OffW:0]     used_sum;
  logic [OffW-1:0]   used_new;
  logic              accept, skip, done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Assemble varints and keep the header byte count.
  always_comb begin
    acc_e    = in_start ? '0 : acc_r;
    nbytes_e = in_start ? '0 : nbytes_r;
    phase_e  = in_start ? KIND_PAYLOAD : phase_r;
    hsize_e  = in_start ? '0 : hdr_size_r;
    hused_e  = in_start ? '0 : hdr_used_r;

    skip = (phase_e == KIND_SERIAL) && (hused_e >= hsize_e);

    if (nbytes_e >= FullByteIdx) begin
      acc_new = {acc_e[ValueW-9:0], in_byte};
      done    = 1'b1;
    end else begin
      acc_new = {acc_e[ValueW-8:0], in_byte[6:0]};
      done    = !in_byte[7];
    end
    len = nbytes_e + 4'd1;

    hsize_v  = (|acc_new[ValueW-1:OffW]) ? OffMax : acc_new[OffW-1:0];
    used_sum = {1'b0, hused_e} + {{(OffW+1-LenW){1'b0}}, len};
    used_new = used_sum[OffW] ? OffMax : used_sum[OffW-1:0];

    acc_nxt      = acc_e;
    nbytes_nxt   = nbytes_e;
    phase_nxt    = phase_e;
    hdr_size_nxt = hsize_e;
    hdr_used_nxt = hused_e;
    push         = 1'b0;
    push_data.kind  = phase_e;
    push_data.value = acc_new;
    push_data.len   = len;
    push_data.last  = 1'b0;

    if (!skip) begin
      if (!done) begin
        acc_nxt    = acc_new;
        nbytes_nxt = len;
      end else begin
        acc_nxt    = '0;
        nbytes_nxt = '0;
        push       = accept;
        case (phase_e)
          KIND_PAYLOAD: phase_nxt = KIND_ROWID;
          KIND_ROWID:   phase_nxt = KIND_HDR_SIZE;
          KIND_HDR_SIZE: begin
            phase_nxt      = KIND_SERIAL;
            hdr_size_nxt   = hsize_v;
            hdr_used_nxt   = {{(OffW-LenW){1'b0}}, len};
            push_data.last = ({{(OffW-LenW){1'b0}}, len} >= hsize_v);
          end
          default: begin
            hdr_used_nxt   = used_new;
            push_data.last = (used_new >= hsize_e);
          end
        endcase
      end
    end
  end

  // Cell state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      nbytes_r   <= '0;
      phase_r    <= KIND_PAYLOAD;
      hdr_size_r <= '0;
      hdr_used_r <= '0;
    end else if (accept) begin
      acc_r      <= acc_nxt;
      nbytes_r   <= nbytes_nxt;
      phase_r    <= phase_nxt;
      hdr_size_r <= hdr_size_nxt;
      hdr_used_r <= hdr_used_nxt;
    end
  end

endmodule

// ===== rtl/rchd_queue.sv =====
`timescale 1ns / 1ps

module rchd_queue import rchd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  varint_t push_data,
  output logic    full,
  output logic    not_empty,
  input  logic    pop,
  output varint_t head
);

  varint_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/rchd_back.sv =====
`timescale 1ns / 1ps

module rchd_back import rchd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  varint_t             head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutDataW-1:0] out_data,
  output kind_t               out_kind,
  output logic                out_last
);

  logic [ColW-1:0]   col_cnt_r, col_cnt_nxt;
  logic [OffW-1:0]   off_sum_r, off_sum_nxt;
  logic              valid_r;
  kind_t             kind_r;
  logic [ValueW-1:0] value_r;
  logic [LenW-1:0]   len_r;
  logic [ColW-1:0]   col_r, col_nxt;
  logic [ClassW-1:0] cls_r, cls_nxt;
  logic [SizeW-1:0]  size_r, size_nxt;
  logic [OffW-1:0]   off_r, off_nxt;
  logic              last_r;
  logic [OffW:0]     off_add;

  assign pop       = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;
  assign out_data  = {1'b0, off_r, size_r, cls_r, col_r, len_r, value_r};

  // Classify serial types and run the column and offset counters.
  always_comb begin
    col_nxt     = '0;
    cls_nxt     = '0;
    size_nxt    = '0;
    off_nxt     = '0;
    col_cnt_nxt = col_cnt_r;
    off_sum_nxt = off_sum_r;
    off_add     = '0;
    case (head.kind)
      KIND_HDR_SIZE: begin
        col_cnt_nxt = '0;
        off_sum_nxt = '0;
      end
      KIND_SERIAL: begin
        if (head.value < FirstVarSerial) begin
          cls_nxt  = small_class(head.value[3:0]);
          size_nxt = {{(SizeW-4){1'b0}}, small_size(head.value[3:0])};
        end else begin
          cls_nxt  = head.value[0] ? CLS_TEXT : CLS_BLOB;
          size_nxt = head.value[ValueW-1:1] - VarSizeBias;
        end
        col_nxt = col_cnt_r;
        off_nxt = off_sum_r;
        if (col_cnt_r != ColMax) begin
          col_cnt_nxt = col_cnt_r + 16'd1;
        end
        off_add = {1'b0, off_sum_r} + {1'b0, size_nxt[OffW-1:0]};
        if ((|size_nxt[SizeW-1:OffW]) || off_add[OffW]) begin
          off_sum_nxt = OffMax;
        end else begin
          off_sum_nxt = off_add[OffW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output valid and per-cell counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      col_cnt_r <= '0;
      off_sum_r <= '0;
    end else begin
      if (pop) begin
        valid_r   <= 1'b1;
        col_cnt_r <= col_cnt_nxt;
        off_sum_r <= off_sum_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head.kind;
      value_r <= head.value;
      len_r   <= head.len;
      col_r   <= col_nxt;
      cls_r   <= cls_nxt;
      size_r  <= size_nxt;
      off_r   <= off_nxt;
      last_r  <= head.last;
    end
  end

endmodule
